// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion that is switched off while the synchronous reset is held.
`define AST_RUN(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion that is checked at every edge, reset included.
`define AST_ALL(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/adcrs_pkg.sv =====
// ----------------------------------------------------------------------------
// ADC channel range and scaling package
// Types and constants shared by the channel range and scaling block.
// ----------------------------------------------------------------------------
package adcrs_pkg;

    // Operation selector carried in tuser.
    typedef enum logic [1:0] {
        KIND_CONVERT     = 2'd0,
        KIND_READ_LIMITS = 2'd1,
        KIND_WRITE_MIN   = 2'd2,
        KIND_WRITE_MAX   = 2'd3
    } t_kind;

    // Range and polarity bits of one channel.
    typedef struct packed {
        logic rng;
        logic bip;
    } t_chan_bits;

    localparam logic [13:0]        SPAN_FULL  = 14'd10000;
    localparam logic [13:0]        SPAN_HALF  = 14'd5000;
    localparam logic signed [13:0] SCALE_STEP = 14'sd5000;
    localparam logic signed [15:0] LIMIT_FULL = 16'sd10000;
    localparam logic signed [28:0] ROUND_BIAS = 29'sd4095;
    localparam int                 CODE_SHIFT = 12;

endpackage

// ===== sv/adcrs_chan_regs.sv =====
// ----------------------------------------------------------------------------
// ADC channel range register file
// Holds the range and bipolar bits of each channel and applies limit writes.
// ----------------------------------------------------------------------------
module adcrs_chan_regs #(
    parameter int CHANNELS = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_wr_en,
    input  adcrs_pkg::t_kind       i_kind,
    input  logic [2:0]             i_channel,
    input  logic signed [15:0]     i_limit,
    output adcrs_pkg::t_chan_bits  o_bits
);
    import adcrs_pkg::*;

    logic [CHANNELS-1:0] r_rng;
    logic [CHANNELS-1:0] r_bip;
    logic                w_ok;
    t_chan_bits          w_cur;
    t_chan_bits          n_bits;

    assign w_ok = {1'b0, i_channel} < 4'(CHANNELS);

    always_comb begin
        w_cur = '0;
        for (int i = 0; i < CHANNELS; i++) begin
            if (i_channel == 3'(i)) begin
                w_cur.rng = r_rng[i];
                w_cur.bip = r_bip[i];
            end
        end
    end

    // Limit writes move the bits by fixed thresholds; other kinds keep them.
    always_comb begin
        n_bits = w_cur;
        unique case (i_kind)
            KIND_WRITE_MIN: begin
                if (i_limit <= -LIMIT_FULL) begin
                    n_bits.rng = 1'b1;
                    n_bits.bip = 1'b1;
                end else if (i_limit < 16'sd0) begin
                    n_bits.rng = 1'b0;
                    n_bits.bip = 1'b1;
                end else begin
                    n_bits.bip = 1'b0;
                end
            end
            KIND_WRITE_MAX: begin
                n_bits.rng = (i_limit >= LIMIT_FULL);
            end
            default: begin
                n_bits = w_cur;
            end
        endcase
    end

    assign o_bits = w_ok ? n_bits : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rng <= '0;
            r_bip <= '0;
        end else if (i_wr_en && w_ok) begin
            for (int i = 0; i < CHANNELS; i++) begin
                if (i_channel == 3'(i)) begin
                    r_rng[i] <= n_bits.rng;
                    r_bip[i] <= n_bits.bip;
                end
            end
        end
    end

endmodule

// ===== sv/adcrs_scale.sv =====
// ----------------------------------------------------------------------------
// ADC code scaler
// Converts a 12-bit conversion code to millivolts for the channel's mode.
// ----------------------------------------------------------------------------
module adcrs_scale (
    input  logic [11:0]            i_code,
    input  adcrs_pkg::t_chan_bits  i_bits,
    output logic signed [14:0]     o_mv
);
    import adcrs_pkg::*;

    logic signed [12:0] w_code;
    logic signed [26:0] w_prod;
    logic [1:0]         w_shamt;
    logic signed [28:0] w_scaled;
    logic signed [28:0] w_biased;

    // Bipolar codes are two's complement; the doubling and the 10 V span are
    // both folded into a left shift of code times 5000.
    assign w_code   = i_bits.bip ? {i_code[11], i_code} : {1'b0, i_code};
    assign w_prod   = w_code * SCALE_STEP;
    assign w_shamt  = {1'b0, i_bits.rng} + {1'b0, i_bits.bip};
    assign w_scaled = 29'(w_prod) <<< w_shamt;

    // Bias negative values so the arithmetic shift truncates toward zero.
    assign w_biased = w_scaled + (w_scaled[28] ? ROUND_BIAS : 29'sd0);
    assign o_mv     = w_biased[CODE_SHIFT+14:CODE_SHIFT];

endmodule

// ===== sv/adc_channel_range_and_scaling.sv =====
// Path: each beat passes through the input register, then the result register.
// Throughput: one beat per cycle unless m_axis_tready stalls; each register
// advances whenever the next stage is free or being drained.
// Reset: synchronous, active low; clears both stage valids and sets every
// channel to the 5 V unipolar range.
// ----------------------------------------------------------------------------
// ADC channel range and scaling
// Per-channel range/polarity keeper and code-to-millivolt converter.
// ----------------------------------------------------------------------------
module adc_channel_range_and_scaling #(
    parameter int CHANNELS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: channel[2:0], raw_sample[14:3], limit_value[30:15], zero[31].
    input  logic [31:0] s_axis_tdata,
    // tuser: kind[1:0].
    input  logic [1:0]  s_axis_tuser,
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: value[14:0], upper_limit[28:15], select_byte[36:29], zero[39:37].
    output logic [39:0] m_axis_tdata
);
    import adcrs_pkg::*;

    // Input register stage. Its payload is not reset; only the valid is.
    logic               r_in_valid;
    t_kind              r_kind;
    logic [2:0]         r_channel;
    logic [11:0]        r_raw;
    logic signed [15:0] r_limit;

    // Result register stage.
    logic               r_out_valid;
    logic [39:0]        r_out_data;

    logic               w_advance;
    t_chan_bits         w_bits;
    logic signed [14:0] w_conv_mv;
    logic signed [14:0] w_value;
    logic [13:0]        w_upper;
    logic [7:0]         w_select;

    // The input stage moves on when the result register is empty or its
    // beat is being taken in this cycle, so a full pipe still takes a beat.
    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_kind    <= t_kind'(s_axis_tuser);
            r_channel <= s_axis_tdata[2:0];
            r_raw     <= s_axis_tdata[14:3];
            r_limit   <= s_axis_tdata[30:15];
        end
    end

    // The register file returns the bits as they stand after this beat's
    // own update, and commits that update only when the beat moves on.
    adcrs_chan_regs #(
        .CHANNELS (CHANNELS)
    ) u_chan_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_advance),
        .i_kind    (r_kind),
        .i_channel (r_channel),
        .i_limit   (r_limit),
        .o_bits    (w_bits)
    );

    adcrs_scale u_scale (
        .i_code (r_raw),
        .i_bits (w_bits),
        .o_mv   (w_conv_mv)
    );

    assign w_upper = w_bits.rng ? SPAN_FULL : SPAN_HALF;

    // Convert gives millivolts, a limits query gives the channel minimum
    // (the negated span in bipolar mode), and both write kinds give zero.
    always_comb begin
        case (r_kind)
            KIND_CONVERT:     w_value = w_conv_mv;
            KIND_READ_LIMITS: w_value = w_bits.bip ? (15'd0 - 15'(w_upper)) : 15'd0;
            default:          w_value = 15'd0;
        endcase
    end

    // Select byte: start bit, channel number, range bit, bipolar bit, two zero bits.
    assign w_select = {1'b1, r_channel, w_bits.rng, w_bits.bip, 2'b00};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_data <= {3'b000, w_select, w_upper, w_value};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

// ===== sv/adcrs_checker.sv =====
// ----------------------------------------------------------------------------
// ADC channel range and scaling checker
// Port-level assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module adcrs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata
);

    // A stalled result beat stays offered with the same contents.
    `AST_RUN(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result beat changed while stalled")

    // Reset empties the result register.
    `AST_ALL(a_rst_empty, i_clk, !i_rst_n |=> !m_axis_tvalid, "result valid after reset")

    // Every beat carries the start bit and an upper limit matching its range bit.
    `AST_RUN(a_sel_upper, i_clk, i_rst_n, m_axis_tvalid |-> m_axis_tdata[36] && (m_axis_tdata[32] ? (m_axis_tdata[28:15] == 14'd10000) : (m_axis_tdata[28:15] == 14'd5000)), "select byte and upper limit disagree")

    // A unipolar channel never reports a negative value.
    `AST_RUN(a_unip_pos, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tdata[31] |-> !m_axis_tdata[14], "negative value on a unipolar channel")

endmodule

bind adc_channel_range_and_scaling adcrs_checker u_adcrs_checker (.*);
